// ===== rtl/core/trajectory_spread_score_defines.svh =====
// assertion macros for trajectory_spread_score
`ifndef TRAJECTORY_SPREAD_SCORE_DEFINES_SVH
`define TRAJECTORY_SPREAD_SCORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define TSS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define TSS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TSS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define TSS_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/core/tss_pkg.sv =====
`default_nettype none
package tss_pkg;
    localparam int HORIZON_W = 26;
    localparam int REF_W     = 20;
    localparam int CFG_W     = 26;
    localparam int CFG_IDX_W = 1;
    localparam int SCORE_W   = 17;

    localparam logic [CFG_IDX_W-1:0] REG_HORIZON = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPREAD  = 1'd1;

    localparam logic [HORIZON_W-1:0] HORIZON_RST = 26'd2000000;
    localparam logic [REF_W-1:0]     REF_RST     = 20'd1024;

    localparam logic FUNC_POINT = 1'b0;
    localparam logic FUNC_END   = 1'b1;

    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_FEW_POINTS  = 2'd1;
    localparam logic [1:0] STATUS_ZERO_REF    = 2'd2;
    localparam logic [1:0] STATUS_FEW_SAMPLES = 2'd3;

    localparam logic [SCORE_W-1:0] SCORE_ONE = 17'd65536;

    typedef struct packed {
        logic start;
        logic done;
    } unit_ctl_t;
endpackage
`default_nettype wire

// ===== rtl/core/tss_sample_store.sv =====
`default_nettype none
module tss_sample_store #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire logic                 aclk,
    input  wire logic                 wr_en,
    input  wire logic [AW-1:0]        wr_addr,
    input  wire logic signed [31:0]   wr_x,
    input  wire logic signed [31:0]   wr_y,
    input  wire logic                 rd_en,
    input  wire logic [AW-1:0]        rd_addr,
    output logic signed [31:0]        rd_x,
    output logic signed [31:0]        rd_y
);
    logic signed [31:0] x_mem [DEPTH];
    logic signed [31:0] y_mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            x_mem[wr_addr] <= wr_x;
            y_mem[wr_addr] <= wr_y;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_x <= x_mem[rd_addr];
            rd_y <= y_mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/tss_mul.sv =====
`default_nettype none
module tss_mul import tss_pkg::*; #(
    parameter int AW = 69,
    parameter int BW = 37,
    parameter int PW = 74
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [AW-1:0] a,
    input  wire logic [BW-1:0] b,
    output unit_ctl_t          ctl,
    output logic [PW-1:0]      prod
);
    localparam int CNTW = $clog2(BW + 1);

    logic [AW-1:0]   a_reg;
    logic [BW-1:0]   b_reg;
    logic [PW-1:0]   acc_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [PW-1:0]   acc_next;

    // msb-first shift and add, one multiplier bit per cycle
    assign acc_next = {acc_reg[PW-2:0], 1'b0} + (b_reg[BW-1] ? PW'(a_reg) : '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && !start && (cnt_reg == CNTW'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(BW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end else if (busy_reg) begin
            acc_reg <= acc_next;
            b_reg   <= {b_reg[BW-2:0], 1'b0};
        end
    end

    assign ctl.start = start;
    assign ctl.done  = done_reg;
    assign prod      = acc_reg;
endmodule
`default_nettype wire

// ===== rtl/core/tss_root.sv =====
`default_nettype none
module tss_root import tss_pkg::*; #(
    parameter int LW = 106,
    parameter int DW = 25
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [LW-1:0]      lim,
    input  wire logic [DW-1:0]      d,
    output unit_ctl_t               ctl,
    output logic [SCORE_W-1:0]      score
);
    localparam int RW   = LW / 2;
    localparam int CNTW = $clog2(RW + 1);

    localparam logic [1:0] R_IDLE = 2'd0;
    localparam logic [1:0] R_SQRT = 2'd1;
    localparam logic [1:0] R_SAT  = 2'd2;
    localparam logic [1:0] R_DIV  = 2'd3;

    logic [1:0]         state_reg;
    logic [LW-1:0]      lim_reg;
    logic [RW+1:0]      rem_reg;
    logic [RW-1:0]      root_reg;
    logic [RW-1:0]      dsh_reg;
    logic [DW-1:0]      d_reg;
    logic [CNTW-1:0]    cnt_reg;
    logic [15:0]        quo_reg;
    logic [SCORE_W-1:0] score_reg;
    logic               done_reg;

    logic [RW+3:0] rem_sh;
    logic [RW+3:0] trial;
    logic          sq_ge;
    logic [RW-1:0] d_full;
    logic          dv_ge;

    assign rem_sh = {rem_reg, lim_reg[LW-1:LW-2]};
    assign trial  = (RW+4)'({root_reg, 2'b01});
    assign sq_ge  = rem_sh >= trial;
    assign d_full = RW'(d_reg) << 16;
    assign dv_ge  = root_reg >= dsh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= R_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            done_reg <= ((state_reg == R_SAT) && (root_reg >= d_full))
                     || ((state_reg == R_DIV) && (cnt_reg == CNTW'(1)));
            unique case (state_reg)
                R_IDLE: begin
                    if (start) begin
                        state_reg <= R_SQRT;
                        cnt_reg   <= CNTW'(RW);
                    end
                end
                R_SQRT: begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CNTW'(1)) begin
                        state_reg <= R_SAT;
                    end
                end
                R_SAT: begin
                    if (root_reg >= d_full) begin
                        state_reg <= R_IDLE;
                    end else begin
                        state_reg <= R_DIV;
                        cnt_reg   <= CNTW'(16);
                    end
                end
                R_DIV: begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CNTW'(1)) begin
                        state_reg <= R_IDLE;
                    end
                end
                default: state_reg <= R_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            R_IDLE: begin
                if (start) begin
                    lim_reg  <= lim;
                    d_reg    <= d;
                    rem_reg  <= '0;
                    root_reg <= '0;
                end
            end
            R_SQRT: begin
                lim_reg  <= {lim_reg[LW-3:0], 2'b00};
                rem_reg  <= sq_ge ? (RW+2)'(rem_sh - trial) : (RW+2)'(rem_sh);
                root_reg <= {root_reg[RW-2:0], sq_ge};
            end
            R_SAT: begin
                dsh_reg <= RW'(d_reg) << 15;
                quo_reg <= '0;
                if (root_reg >= d_full) begin
                    score_reg <= SCORE_ONE;
                end
            end
            R_DIV: begin
                if (dv_ge) begin
                    root_reg <= root_reg - dsh_reg;
                end
                quo_reg <= {quo_reg[14:0], dv_ge};
                dsh_reg <= {1'b0, dsh_reg[RW-1:1]};
                if (cnt_reg == CNTW'(1)) begin
                    score_reg <= {1'b0, quo_reg[14:0], dv_ge};
                end
            end
            default: ;
        endcase
    end

    assign ctl.start = start;
    assign ctl.done  = done_reg;
    assign score     = score_reg;
endmodule
`default_nettype wire

// ===== rtl/core/trajectory_spread_score.sv =====
// trajectory_spread_score
// input channel s_*: one transfer per trajectory point (s_func = 0) or end
// of batch (s_func = 1). configuration via cfg_we/cfg_index/cfg_wdata, one
// write per cycle, only while idle.
// point transfers produce no result and leave s_ready high; the block is
// ready again on the next cycle.
// an end transfer yields one result on m_*. with a nonzero status the
// sequencer goes straight to the output stage. otherwise it reads the
// n samples from the sample store and drives one shift-add multiplier,
// then the square root and divide unit. s_ready stays low for the whole
// computation.
// the result sits in an output register; point transfers are taken while it
// waits, a next end transfer is computed and then held until m_ready frees
// the output register.
// reset (aresetn low, synchronous) restores register defaults, empties the
// batch and drops any pending result; the sample store needs no clearing.
`default_nettype none
`include "trajectory_spread_score_defines.svh"
module trajectory_spread_score import tss_pkg::*; #(
    parameter int MAX_SAMPLES = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_wdata,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_func,
    input  wire logic signed [31:0]    s_traj_age_us,
    input  wire logic [30:0]           s_time_from_start_us,
    input  wire logic signed [31:0]    s_pos_x,
    input  wire logic signed [31:0]    s_pos_y,
    input  wire logic                  s_first_of_traj,
    input  wire logic                  s_last_of_traj,
    input  wire logic                  s_is_current,
    input  wire logic [15:0]           s_scored_point_count,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [SCORE_W-1:0]         m_score,
    output logic [1:0]                 m_status,
    output logic [5:0]                 m_sample_count,
    output logic                       m_samples_dropped
);
    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int MW = 32 + AW;
    localparam int SW = MW + 1;
    localparam int QW = 64 + AW;
    localparam int NW = 64 + 2 * AW;
    localparam int LW = NW + 32;
    localparam int DW = REF_W + AW;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_READ = 4'd1;
    localparam logic [3:0] ST_LOAD = 4'd2;
    localparam logic [3:0] ST_MX   = 4'd3;
    localparam logic [3:0] ST_MY   = 4'd4;
    localparam logic [3:0] ST_MN   = 4'd5;
    localparam logic [3:0] ST_MSX  = 4'd6;
    localparam logic [3:0] ST_MSY  = 4'd7;
    localparam logic [3:0] ST_ROOT = 4'd8;
    localparam logic [3:0] ST_FIN  = 4'd9;

    logic [3:0]             state_reg;
    logic [HORIZON_W-1:0]   horizon_reg;
    logic [REF_W-1:0]       ref_reg;
    logic [CW-1:0]          held_reg;
    logic                   ovf_reg;
    logic                   pf_reg;
    logic signed [31:0]     lat_x_reg;
    logic signed [31:0]     lat_y_reg;
    logic signed [33:0]     need_reg;
    logic [CW-1:0]          n_reg;
    logic [CW-1:0]          idx_reg;
    logic [QW-1:0]          sq_reg;
    logic signed [SW-1:0]   sx_reg;
    logic signed [SW-1:0]   sy_reg;
    logic [NW-1:0]          num_reg;
    logic [DW-1:0]          dd_reg;
    logic [1:0]             stat_reg;
    logic [5:0]             cnt_reg;
    logic                   drop_reg;
    logic [SCORE_W-1:0]     sc_reg;
    logic                   m_valid_reg;
    logic [SCORE_W-1:0]     m_score_reg;
    logic [1:0]             m_status_reg;
    logic [5:0]             m_count_reg;
    logic                   m_drop_reg;

    logic                   s_xfer;
    logic                   pt_xfer;
    logic                   end_xfer;
    logic signed [33:0]     hz_ext;
    logic signed [33:0]     need_new;
    logic signed [33:0]     eff_need;
    logic                   eff_pf;
    logic                   hit;
    logic                   take;
    logic                   elig;
    logic                   full;
    logic signed [31:0]     smp_x;
    logic signed [31:0]     smp_y;
    logic                   wr_en;
    logic [1:0]             status_new;

    logic                   rd_en;
    logic signed [31:0]     rd_x;
    logic signed [31:0]     rd_y;
    logic [31:0]            mag_x;
    logic [31:0]            mag_y;
    logic [MW-1:0]          mag_sx;
    logic [MW-1:0]          mag_sy;
    logic                   mul_start;
    logic [QW-1:0]          mul_a;
    logic [MW-1:0]          mul_b;
    unit_ctl_t              mul_ctl;
    logic [NW-1:0]          mul_prod;
    logic                   root_start;
    logic [LW-1:0]          root_lim;
    unit_ctl_t              root_ctl;
    logic [SCORE_W-1:0]     root_score;
    logic                   out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_xfer   = s_valid && s_ready;
    assign pt_xfer  = s_xfer && (s_func == FUNC_POINT);
    assign end_xfer = s_xfer && (s_func == FUNC_END);

    // offset selection and latch of the point at the common instant
    assign hz_ext   = $signed({8'b0, horizon_reg});
    assign need_new = s_is_current ? hz_ext : hz_ext + 34'(s_traj_age_us);
    assign eff_need = s_first_of_traj ? need_new : need_reg;
    assign eff_pf   = s_first_of_traj ? 1'b0 : pf_reg;
    assign hit      = !eff_pf && ($signed({3'b0, s_time_from_start_us}) >= eff_need);
    assign take     = !eff_pf && (hit || s_last_of_traj);
    assign smp_x    = take ? s_pos_x : lat_x_reg;
    assign smp_y    = take ? s_pos_y : lat_y_reg;
    assign elig     = (eff_need > 34'sd0) || s_is_current;
    assign full     = (held_reg == CW'(MAX_SAMPLES));
    assign wr_en    = pt_xfer && s_last_of_traj && elig && !full;

    always_comb begin
        if (s_scored_point_count < 16'd2) begin
            status_new = STATUS_FEW_POINTS;
        end else if (ref_reg == '0) begin
            status_new = STATUS_ZERO_REF;
        end else if (held_reg < CW'(2)) begin
            status_new = STATUS_FEW_SAMPLES;
        end else begin
            status_new = STATUS_OK;
        end
    end

    tss_sample_store #(
        .DEPTH (MAX_SAMPLES),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (held_reg[AW-1:0]),
        .wr_x    (smp_x),
        .wr_y    (smp_y),
        .rd_en   (rd_en),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_x    (rd_x),
        .rd_y    (rd_y)
    );

    assign mag_x  = rd_x[31] ? 32'(-rd_x) : 32'(rd_x);
    assign mag_y  = rd_y[31] ? 32'(-rd_y) : 32'(rd_y);
    assign mag_sx = sx_reg[SW-1] ? MW'(-sx_reg) : MW'(sx_reg);
    assign mag_sy = sy_reg[SW-1] ? MW'(-sy_reg) : MW'(sy_reg);

    // operand steering for the shared multiplier and root unit
    always_comb begin
        rd_en      = 1'b0;
        mul_start  = 1'b0;
        mul_a      = QW'(mag_x);
        mul_b      = MW'(mag_x);
        root_start = 1'b0;
        root_lim   = {num_reg - mul_prod, 32'b0};
        unique case (state_reg)
            ST_READ: rd_en = 1'b1;
            ST_LOAD: mul_start = 1'b1;
            ST_MX: begin
                mul_start = mul_ctl.done;
                mul_a     = QW'(mag_y);
                mul_b     = MW'(mag_y);
            end
            ST_MY: begin
                mul_start = mul_ctl.done && (idx_reg + 1'b1 == n_reg);
                mul_a     = sq_reg + QW'(mul_prod);
                mul_b     = MW'(n_reg);
            end
            ST_MN: begin
                mul_start = mul_ctl.done;
                mul_a     = QW'(mag_sx);
                mul_b     = mag_sx;
            end
            ST_MSX: begin
                mul_start = mul_ctl.done;
                mul_a     = QW'(mag_sy);
                mul_b     = mag_sy;
            end
            ST_MSY: root_start = mul_ctl.done;
            default: ;
        endcase
    end

    tss_mul #(
        .AW (QW),
        .BW (MW),
        .PW (NW)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .ctl     (mul_ctl),
        .prod    (mul_prod)
    );

    tss_root #(
        .LW (LW),
        .DW (DW)
    ) u_root (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (root_start),
        .lim     (root_lim),
        .d       (dd_reg),
        .ctl     (root_ctl),
        .score   (root_score)
    );

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            horizon_reg <= HORIZON_RST;
            ref_reg     <= REF_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_HORIZON: horizon_reg <= cfg_wdata[HORIZON_W-1:0];
                REG_SPREAD:  ref_reg     <= cfg_wdata[REF_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            held_reg    <= '0;
            ovf_reg     <= 1'b0;
            pf_reg      <= 1'b0;
            lat_x_reg   <= '0;
            lat_y_reg   <= '0;
            need_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if ((state_reg == ST_FIN) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (pt_xfer) begin
                        if (s_first_of_traj) begin
                            need_reg <= need_new;
                        end
                        lat_x_reg <= smp_x;
                        lat_y_reg <= smp_y;
                        pf_reg    <= s_last_of_traj ? 1'b0 : (eff_pf || hit);
                        if (s_last_of_traj && elig) begin
                            if (full) begin
                                ovf_reg <= 1'b1;
                            end else begin
                                held_reg <= held_reg + 1'b1;
                            end
                        end
                    end else if (end_xfer) begin
                        held_reg  <= '0;
                        ovf_reg   <= 1'b0;
                        pf_reg    <= 1'b0;
                        state_reg <= (status_new == STATUS_OK) ? ST_READ : ST_FIN;
                    end
                end
                ST_READ: state_reg <= ST_LOAD;
                ST_LOAD: state_reg <= ST_MX;
                ST_MX: begin
                    if (mul_ctl.done) begin
                        state_reg <= ST_MY;
                    end
                end
                ST_MY: begin
                    if (mul_ctl.done) begin
                        state_reg <= (idx_reg + 1'b1 == n_reg) ? ST_MN : ST_READ;
                    end
                end
                ST_MN: begin
                    if (mul_ctl.done) begin
                        state_reg <= ST_MSX;
                    end
                end
                ST_MSX: begin
                    if (mul_ctl.done) begin
                        state_reg <= ST_MSY;
                    end
                end
                ST_MSY: begin
                    if (mul_ctl.done) begin
                        state_reg <= ST_ROOT;
                    end
                end
                ST_ROOT: begin
                    if (root_ctl.done) begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (end_xfer) begin
                    n_reg    <= held_reg;
                    idx_reg  <= '0;
                    sq_reg   <= '0;
                    sx_reg   <= '0;
                    sy_reg   <= '0;
                    dd_reg   <= DW'(held_reg) * DW'(ref_reg);
                    stat_reg <= status_new;
                    cnt_reg  <= 6'(held_reg);
                    drop_reg <= ovf_reg;
                    sc_reg   <= '0;
                end
            end
            ST_MX: begin
                if (mul_ctl.done) begin
                    sq_reg <= sq_reg + QW'(mul_prod);
                end
            end
            ST_MY: begin
                if (mul_ctl.done) begin
                    sq_reg  <= sq_reg + QW'(mul_prod);
                    sx_reg  <= sx_reg + SW'(rd_x);
                    sy_reg  <= sy_reg + SW'(rd_y);
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            ST_MN: begin
                if (mul_ctl.done) begin
                    num_reg <= mul_prod;
                end
            end
            ST_MSX: begin
                if (mul_ctl.done) begin
                    num_reg <= num_reg - mul_prod;
                end
            end
            ST_ROOT: begin
                if (root_ctl.done) begin
                    sc_reg <= root_score;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    m_score_reg  <= sc_reg;
                    m_status_reg <= stat_reg;
                    m_count_reg  <= cnt_reg;
                    m_drop_reg   <= drop_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_valid           = m_valid_reg;
    assign m_score           = m_score_reg;
    assign m_status          = m_status_reg;
    assign m_sample_count    = m_count_reg;
    assign m_samples_dropped = m_drop_reg;

    `TSS_ASSERT_NXT(a_busy_after_end, aclk, aresetn, end_xfer, !s_ready)
    `TSS_ASSERT_IMP(a_status_zero_score, aclk, aresetn,
        m_valid && (m_status != STATUS_OK), m_score == '0)
    `TSS_ASSERT_IMP(a_score_sat, aclk, aresetn, m_valid, m_score <= SCORE_ONE)
    `TSS_ASSERT_IMP(a_held_bound, aclk, aresetn, 1'b1, held_reg <= CW'(MAX_SAMPLES))
endmodule
`default_nettype wire

// ===== test/tb_trajectory_spread_score.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tb_trajectory_spread_score;
    import tss_pkg::*;

    localparam int STORE_DEPTH = 32;
    localparam int CYCLE_LIMIT = 20000000;
    localparam int LONG_HOLD   = 6000;
    localparam int SETTLE      = 200;

    typedef struct packed {
        logic               func;
        logic signed [31:0] age;
        logic [30:0]        tfs;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic               first;
        logic               last;
        logic               cur;
        logic [15:0]        spc;
    } point_t;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [1:0]         status;
        logic [5:0]         cnt;
        logic               drop;
    } spread_res_t;

    typedef struct packed {
        point_t      it;
        logic        typed;
        spread_res_t res;
    } dir_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_func = 1'b0;
    logic signed [31:0]   s_traj_age_us = '0;
    logic [30:0]          s_time_from_start_us = '0;
    logic signed [31:0]   s_pos_x = '0;
    logic signed [31:0]   s_pos_y = '0;
    logic                 s_first_of_traj = 1'b0;
    logic                 s_last_of_traj = 1'b0;
    logic                 s_is_current = 1'b0;
    logic [15:0]          s_scored_point_count = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [SCORE_W-1:0]   m_score;
    logic [1:0]           m_status;
    logic [5:0]           m_sample_count;
    logic                 m_samples_dropped;

    trajectory_spread_score u_dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_wdata            (cfg_wdata),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_func               (s_func),
        .s_traj_age_us        (s_traj_age_us),
        .s_time_from_start_us (s_time_from_start_us),
        .s_pos_x              (s_pos_x),
        .s_pos_y              (s_pos_y),
        .s_first_of_traj      (s_first_of_traj),
        .s_last_of_traj       (s_last_of_traj),
        .s_is_current         (s_is_current),
        .s_scored_point_count (s_scored_point_count),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_score              (m_score),
        .m_status             (m_status),
        .m_sample_count       (m_sample_count),
        .m_samples_dropped    (m_samples_dropped)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state
    logic [HORIZON_W-1:0] mdl_horizon = HORIZON_RST;
    logic [REF_W-1:0]     mdl_ref = REF_RST;
    logic signed [31:0]   smp_x [STORE_DEPTH];
    logic signed [31:0]   smp_y [STORE_DEPTH];
    int                   held = 0;
    bit                   ovf = 0;
    bit                   found = 0;
    logic signed [31:0]   lat_x = '0;
    logic signed [31:0]   lat_y = '0;
    longint               need = 0;

    spread_res_t pending_scores [$];
    dir_row_t    dir_tab [$];
    int          errors = 0;
    int          items_sent = 0;
    int          ends_sent = 0;
    int          results_seen = 0;
    int          cycles = 0;
    bit          calm = 0;
    bit          hold_ask = 0;
    int          hold_left = 0;
    int          gap_left = 0;

    function automatic logic [SCORE_W-1:0] spread_calc();
        logic signed [127:0] sx, sy, sq, nsg;
        logic [127:0] num, d, lim, t;
        logic [16:0] s, c;
        sx = 0;
        sy = 0;
        sq = 0;
        for (int i = 0; i < held; i++) begin
            sx = sx + smp_x[i];
            sy = sy + smp_y[i];
            sq = sq + smp_x[i] * smp_x[i] + smp_y[i] * smp_y[i];
        end
        nsg = sq * held - sx * sx - sy * sy;
        num = nsg;
        d = held * mdl_ref;
        if (d * d <= num) begin
            return SCORE_ONE;
        end
        lim = num << 32;
        s = '0;
        for (int b = 15; b >= 0; b--) begin
            c = s | (17'd1 << b);
            t = c * d;
            if (t * t <= lim) s = c;
        end
        return s;
    endfunction

    task automatic expect_result(input spread_res_t r);
        pending_scores = {pending_scores, r};
    endtask

    task automatic predict_item(input point_t it, output bit got, output spread_res_t r);
        got = 0;
        r = '0;
        if (it.func == FUNC_POINT) begin
            if (it.first) begin
                found = 0;
                need = it.cur ? longint'(mdl_horizon) : longint'(mdl_horizon) + longint'(it.age);
            end
            if (!found && longint'(it.tfs) >= need) begin
                lat_x = it.px;
                lat_y = it.py;
                found = 1;
            end
            if (it.last) begin
                if (!found) begin
                    lat_x = it.px;
                    lat_y = it.py;
                end
                if (need > 0 || it.cur) begin
                    if (held < STORE_DEPTH) begin
                        smp_x[held] = lat_x;
                        smp_y[held] = lat_y;
                        held++;
                    end else begin
                        ovf = 1;
                    end
                end
                found = 0;
            end
        end else begin
            got = 1;
            if (it.spc < 2) r.status = STATUS_FEW_POINTS;
            else if (mdl_ref == 0) r.status = STATUS_ZERO_REF;
            else if (held < 2) r.status = STATUS_FEW_SAMPLES;
            else begin
                r.status = STATUS_OK;
                r.score = spread_calc();
            end
            r.cnt = held[5:0];
            r.drop = ovf;
            held = 0;
            ovf = 0;
            found = 0;
        end
    endtask

    // drive one item, return once the transfer has happened
    task automatic send_item(input point_t it, input bit typed, input spread_res_t typed_res);
        bit got;
        spread_res_t r;
        s_valid <= 1'b1;
        s_func <= it.func;
        s_traj_age_us <= it.age;
        s_time_from_start_us <= it.tfs;
        s_pos_x <= it.px;
        s_pos_y <= it.py;
        s_first_of_traj <= it.first;
        s_last_of_traj <= it.last;
        s_is_current <= it.cur;
        s_scored_point_count <= it.spc;
        do @(posedge aclk); while (!s_ready);
        predict_item(it, got, r);
        if (got) begin
            expect_result(typed ? typed_res : r);
            ends_sent++;
        end
        items_sent++;
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_scores.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_HORIZON) mdl_horizon = val[HORIZON_W-1:0];
        else mdl_ref = val[REF_W-1:0];
    endtask

    function automatic point_t mk_pt(logic signed [31:0] age, logic [30:0] tfs,
                                     logic signed [31:0] px, logic signed [31:0] py,
                                     logic first, logic last, logic cur);
        point_t p;
        p = '{FUNC_POINT, age, tfs, px, py, first, last, cur, 16'd0};
        return p;
    endfunction

    function automatic point_t mk_end(logic [15:0] spc);
        point_t p;
        p = point_t'({$urandom, $urandom, $urandom, $urandom});
        p.func = FUNC_END;
        p.spc = spc;
        return p;
    endfunction

    task automatic add_row(input point_t it, input bit typed, input spread_res_t r);
        dir_row_t row;
        row = '{it, typed, r};
        dir_tab = {dir_tab, row};
    endtask

    task automatic send_batch();
        int ntraj, len;
        logic signed [31:0] cx, cy, age;
        logic [30:0] base, step;
        longint tneed, b;
        logic cur;
        point_t p;
        ntraj = ($urandom_range(0, 15) == 0) ? $urandom_range(33, 36) : $urandom_range(0, 6);
        cx = $urandom;
        cy = $urandom;
        for (int t = 0; t < ntraj; t++) begin
            len = $urandom_range(1, 5);
            cur = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 3) == 0) age = $urandom;
            else age = $signed($urandom_range(0, 4000000)) - 1000000;
            tneed = cur ? longint'(mdl_horizon) : longint'(mdl_horizon) + longint'(age);
            b = tneed - $urandom_range(0, 2000000);
            if (b < 0) b = 0;
            if (b > 32'h7fff_0000) b = 32'h7fff_0000;
            base = b[30:0];
            step = 31'($urandom_range(0, 1000000));
            for (int k = 0; k < len; k++) begin
                p = mk_pt(age, 31'(base + step * k),
                          32'(cx + $signed($urandom_range(0, 32767)) - 16384),
                          32'(cy + $signed($urandom_range(0, 32767)) - 16384),
                          k == 0, k == len - 1, cur);
                if ($urandom_range(0, 7) == 0) p.tfs = 31'($urandom);
                if ($urandom_range(0, 5) == 0) begin
                    p.px = $urandom;
                    p.py = $urandom;
                end
                if ($urandom_range(0, 9) == 0) p.first = ~p.first;
                if ($urandom_range(0, 9) == 0) p.last = ~p.last;
                if ($urandom_range(0, 9) == 0) p.cur = ~p.cur;
                send_item(p, 0, '0);
                if ($urandom_range(0, 19) == 0) begin
                    p = point_t'({$urandom, $urandom, $urandom, $urandom});
                    p.func = FUNC_POINT;
                    send_item(p, 0, '0);
                end
            end
        end
        send_item(mk_end(16'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 1)
                                                          : $urandom_range(2, 65535))),
                  0, '0);
    endtask

    task automatic run_phase(input int target, input bit pressure);
        int start;
        start = items_sent;
        while (items_sent - start < target) begin
            send_batch();
            if (pressure && items_sent - start > target / 3) begin
                hold_ask = 1;
                pressure = 0;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (hold_ask) begin
            hold_ask = 0;
            hold_left = LONG_HOLD;
            m_ready <= 1'b0;
        end else if (calm) begin
            m_ready <= 1'b1;
        end else if (gap_left > 0) begin
            gap_left--;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            gap_left = $urandom_range(0, 12);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        spread_res_t e;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_scores.size() == 0) begin
                $error("result transfer with nothing expected");
                errors++;
            end else begin
                e = pending_scores.pop_front();
                if (m_score !== e.score) begin
                    $error("score expected %0d actual %0d", e.score, m_score);
                    errors++;
                end
                if (m_status !== e.status) begin
                    $error("status expected %0d actual %0d", e.status, m_status);
                    errors++;
                end
                if (m_sample_count !== e.cnt) begin
                    $error("sample_count expected %0d actual %0d", e.cnt, m_sample_count);
                    errors++;
                end
                if (m_samples_dropped !== e.drop) begin
                    $error("samples_dropped expected %0d actual %0d", e.drop,
                           m_samples_dropped);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        spread_res_t nr;
        nr = '0;
        // directed table, reset configuration
        add_row(mk_end(16'd0), 1, '{'0, STATUS_FEW_POINTS, 6'd0, 1'b0});
        add_row(mk_end(16'd1), 1, '{'0, STATUS_FEW_POINTS, 6'd0, 1'b0});
        add_row(mk_end(16'd65535), 1, '{'0, STATUS_FEW_SAMPLES, 6'd0, 1'b0});
        add_row(mk_pt(0, 0, 32'sh7fffffff, 32'sh80000000, 1, 1, 1), 0, nr);
        add_row(mk_end(16'd2), 1, '{'0, STATUS_FEW_SAMPLES, 6'd1, 1'b0});
        add_row(mk_pt(0, 0, 0, 0, 1, 1, 1), 0, nr);
        add_row(mk_pt(0, 0, 32'sh80000000, 32'sh7fffffff, 1, 1, 1), 0, nr);
        add_row(mk_end(16'd2), 1, '{SCORE_ONE, STATUS_OK, 6'd2, 1'b0});
        add_row(mk_pt(0, 0, 100, 10, 1, 0, 0), 0, nr);
        add_row(mk_pt(0, 2000000, 200, 20, 0, 0, 0), 0, nr);
        add_row(mk_pt(0, 31'h7fffffff, 300, 30, 0, 1, 0), 0, nr);
        add_row(mk_pt(32'sh80000000, 0, 999, 999, 1, 1, 0), 0, nr);
        add_row(mk_pt(32'sh7fffffff, 2000000, 5000, -3000, 1, 0, 1), 0, nr);
        add_row(mk_pt(0, 31'h7fffffff, 9, 9, 0, 1, 0), 0, nr);
        add_row(mk_pt(0, 5, -7000, 4000, 0, 1, 1), 0, nr);
        add_row(mk_end(16'd3), 0, nr);
        add_row(mk_pt(32'sh7fffffff, 0, 1024, 0, 1, 1, 0), 0, nr);
        add_row(mk_pt(0, 0, -1024, 0, 1, 1, 1), 0, nr);
        add_row(mk_end(16'd2), 0, nr);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (dir_tab[i]) send_item(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].res);
        drain();

        write_reg(REG_HORIZON, CFG_W'($urandom_range(0, 60000000)));
        write_reg(REG_SPREAD, CFG_W'($urandom_range(1, 1048575)));
        run_phase(300, 1);
        drain();
        run_phase(60, 0);
        drain();
        write_reg(REG_HORIZON, '0);
        write_reg(REG_SPREAD, '0);
        run_phase(200, 0);
        drain();
        write_reg(REG_HORIZON, CFG_W'(60000000));
        write_reg(REG_SPREAD, CFG_W'(1048575));
        run_phase(250, 0);
        drain();
        write_reg(REG_HORIZON, CFG_W'($urandom_range(0, 60000000)));
        write_reg(REG_SPREAD, CFG_W'(1));
        run_phase(250, 0);
        drain();
        write_reg(REG_HORIZON, CFG_W'($urandom_range(0, 4000000)));
        write_reg(REG_SPREAD, CFG_W'($urandom_range(1, 4096)));
        run_phase(350, 0);
        drain();
        calm = 1;
        write_reg(REG_HORIZON, CFG_W'(HORIZON_RST));
        write_reg(REG_SPREAD, CFG_W'($urandom_range(256, 65535)));
        run_phase(200, 0);
        drain();

        $display("covered %0d input transfers, %0d end-of-batch, %0d results checked",
                 items_sent, ends_sent, results_seen);
        $display("configs: reset, zero and full scale horizon/reference, random mid values");
        if (errors == 0 && pending_scores.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== trajectory_spread_score.f =====
+incdir+rtl/core
rtl/core/tss_pkg.sv
rtl/core/tss_sample_store.sv
rtl/core/tss_mul.sv
rtl/core/tss_root.sv
rtl/core/trajectory_spread_score.sv
test/tb_trajectory_spread_score.sv
